// ----- hw/rtl/grmc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmc_pkg
// Shared types and codes of the regional minima counter.
// ----------------------------------------------------------------------------
package grmc_pkg;

  localparam int CFG_W = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_SCANW,
    S_POP,
    S_POPW,
    S_HLAT,
    S_NB,
    S_NBW,
    S_DONE
  } fill_state_t;

  typedef struct packed {
    logic idle;
    logic done;
  } fill_stat_t;

endpackage

// ----- hw/rtl/grmc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module grmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/grmc_fill.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmc_fill
// Flood-fill sequencer: clears the visited map, then walks every plateau with
// a stack and counts those without a strictly lower neighbor.
// ----------------------------------------------------------------------------
module grmc_fill #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  parameter int VALUE_BITS = 16,
  parameter int ADDR_W = 12,
  parameter int TOT_W = 13
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [grmc_pkg::CFG_W-1:0]  rows,
  input  logic [grmc_pkg::CFG_W-1:0]  cols,
  input  logic [TOT_W-1:0]            total,
  input  logic                        out_free,
  output logic [ADDR_W-1:0]           h_raddr,
  input  logic [VALUE_BITS-1:0]       h_rdata,
  output grmc_pkg::fill_stat_t        stat,
  output logic [TOT_W-1:0]            count
);
  import grmc_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int MW = (RW > CW) ? RW : CW;
  localparam int CMP_W = ((MW > CFG_W) ? MW : CFG_W) + 1;
  localparam int SW = ADDR_W + RW + CW;

  fill_state_t state_r, state_nxt;

  logic [ADDR_W-1:0]     ci_r, ci_nxt;
  logic [RW-1:0]         sr_r, sr_nxt, cr_r, cr_nxt, nr_r, nr_nxt;
  logic [CW-1:0]         sc_r, sc_nxt, cc_r, cc_nxt, nc_r, nc_nxt;
  logic [ADDR_W-1:0]     sidx_r, sidx_nxt, cidx_r, cidx_nxt, nidx_r, nidx_nxt;
  logic [VALUE_BITS-1:0] h_r, h_nxt;
  logic [1:0]            k_r, k_nxt;
  logic [TOT_W-1:0]      sp_r, sp_nxt, cnt_r, cnt_nxt;
  logic                  min_r, min_nxt;

  logic              vis_we, vis_wdata;
  logic [ADDR_W-1:0] vis_waddr, vis_raddr;
  logic              vis_rdata;
  logic              stk_we;
  logic [ADDR_W-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0]     stk_wdata, stk_rdata;

  logic              start_last, clear_last;
  logic              nb_ok;
  logic [RW-1:0]     nb_r;
  logic [CW-1:0]     nb_c;
  logic [ADDR_W-1:0] nb_idx;
  logic [RW-1:0]     sr_inc;
  logic [CW-1:0]     sc_inc;
  logic              sc_wrap;

  grmc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (vis_raddr),
    .rdata (vis_rdata)
  );

  grmc_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign start_last = (TOT_W'(sidx_r) == total - 1'b1);
  assign clear_last = (TOT_W'(ci_r) == total - 1'b1);
  assign sc_inc = sc_r + 1'b1;
  assign sr_inc = sr_r + 1'b1;
  assign sc_wrap = (CMP_W'(sc_r) + CMP_W'(1) == CMP_W'(cols));

  always_comb begin
    nb_ok  = 1'b0;
    nb_r   = cr_r;
    nb_c   = cc_r;
    nb_idx = cidx_r;
    unique case (k_r)
      2'd0: begin
        nb_ok  = (cr_r != '0);
        nb_r   = cr_r - 1'b1;
        nb_idx = cidx_r - ADDR_W'(cols);
      end
      2'd1: begin
        nb_ok  = (CMP_W'(cr_r) + 1'b1 < CMP_W'(rows));
        nb_r   = cr_r + 1'b1;
        nb_idx = cidx_r + ADDR_W'(cols);
      end
      2'd2: begin
        nb_ok  = (cc_r != '0);
        nb_c   = cc_r - 1'b1;
        nb_idx = cidx_r - 1'b1;
      end
      default: begin
        nb_ok  = (CMP_W'(cc_r) + 1'b1 < CMP_W'(cols));
        nb_c   = cc_r + 1'b1;
        nb_idx = cidx_r + 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_CLEAR;
      S_CLEAR: if (clear_last) state_nxt = S_SCAN;
      S_SCAN:  state_nxt = S_SCANW;
      S_SCANW: begin
        if (!vis_rdata) state_nxt = S_POP;
        else if (start_last) state_nxt = S_DONE;
        else state_nxt = S_SCAN;
      end
      S_POP: begin
        if (sp_r != '0) state_nxt = S_POPW;
        else if (start_last) state_nxt = S_DONE;
        else state_nxt = S_SCAN;
      end
      S_POPW:  state_nxt = S_HLAT;
      S_HLAT:  state_nxt = S_NB;
      S_NB: begin
        if (nb_ok) state_nxt = S_NBW;
        else if (k_r == 2'd3) state_nxt = S_POP;
      end
      S_NBW:   state_nxt = (k_r == 2'd3) ? S_POP : S_NB;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ci_nxt = ci_r;
    sr_nxt = sr_r; sc_nxt = sc_r; sidx_nxt = sidx_r;
    cr_nxt = cr_r; cc_nxt = cc_r; cidx_nxt = cidx_r;
    nr_nxt = nr_r; nc_nxt = nc_r; nidx_nxt = nidx_r;
    h_nxt = h_r; k_nxt = k_r; sp_nxt = sp_r; cnt_nxt = cnt_r; min_nxt = min_r;
    vis_we = 1'b0; vis_waddr = ci_r; vis_wdata = 1'b0; vis_raddr = sidx_r;
    stk_we = 1'b0; stk_waddr = sp_r[ADDR_W-1:0]; stk_wdata = {sidx_r, sr_r, sc_r};
    stk_raddr = sp_r[ADDR_W-1:0] - 1'b1;
    h_raddr = nidx_r;
    stat.idle = 1'b0;
    stat.done = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        stat.idle = 1'b1;
        ci_nxt = '0;
      end
      S_CLEAR: begin
        vis_we = 1'b1;
        ci_nxt = ci_r + 1'b1;
        sr_nxt = '0; sc_nxt = '0; sidx_nxt = '0;
        cnt_nxt = '0;
      end
      S_SCAN: begin
      end
      S_SCANW: begin
        if (!vis_rdata) begin
          vis_we = 1'b1; vis_waddr = sidx_r; vis_wdata = 1'b1;
          stk_we = 1'b1; stk_waddr = '0;
          sp_nxt = TOT_W'(1);
          min_nxt = 1'b1;
        end else if (!start_last) begin
          sidx_nxt = sidx_r + 1'b1;
          if (sc_wrap) begin
            sc_nxt = '0; sr_nxt = sr_inc;
          end else begin
            sc_nxt = sc_inc;
          end
        end
      end
      S_POP: begin
        if (sp_r != '0) begin
          sp_nxt = sp_r - 1'b1;
        end else begin
          cnt_nxt = cnt_r + TOT_W'(min_r);
          if (!start_last) begin
            sidx_nxt = sidx_r + 1'b1;
            if (sc_wrap) begin
              sc_nxt = '0; sr_nxt = sr_inc;
            end else begin
              sc_nxt = sc_inc;
            end
          end
        end
      end
      S_POPW: begin
        {cidx_nxt, cr_nxt, cc_nxt} = stk_rdata;
        h_raddr = stk_rdata[SW-1 -: ADDR_W];
      end
      S_HLAT: begin
        h_nxt = h_rdata;
        k_nxt = 2'd0;
      end
      S_NB: begin
        if (nb_ok) begin
          h_raddr = nb_idx; vis_raddr = nb_idx;
          nr_nxt = nb_r; nc_nxt = nb_c; nidx_nxt = nb_idx;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_NBW: begin
        if ($signed(h_rdata) < $signed(h_r)) begin
          min_nxt = 1'b0;
        end else if ((h_rdata == h_r) && !vis_rdata) begin
          vis_we = 1'b1; vis_waddr = nidx_r; vis_wdata = 1'b1;
          stk_we = 1'b1; stk_wdata = {nidx_r, nr_r, nc_r};
          sp_nxt = sp_r + 1'b1;
        end
        k_nxt = k_r + 1'b1;
      end
      S_DONE: begin
        stat.done = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    ci_r <= ci_nxt;
    sr_r <= sr_nxt; sc_r <= sc_nxt; sidx_r <= sidx_nxt;
    cr_r <= cr_nxt; cc_r <= cc_nxt; cidx_r <= cidx_nxt;
    nr_r <= nr_nxt; nc_r <= nc_nxt; nidx_r <= nidx_nxt;
    h_r <= h_nxt; k_r <= k_nxt; sp_r <= sp_nxt; cnt_r <= cnt_nxt; min_r <= min_nxt;
  end

  assign count = cnt_r;

endmodule

// ----- hw/rtl/grid_regional_minima_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_regional_minima_counter
// Loads a height grid one cell per cycle, then counts 4-connected plateaus
// without a strictly lower neighbor.
// Sequence: after the marked cell, the visited map is cleared over rows*cols
//   cells, then every cell is scanned; each unvisited cell starts a flood fill
//   that pops each plateau cell and checks its in-grid neighbors; the minima
//   count updates as each fill ends, then goes to the result register.
// Throughput: one cell per cycle while loading; the marked cell holds in_ready
//   low for the whole count and until the result register is free.
// Reset: control and grid size (64 x 64) reset; memories are not cleared.
// ----------------------------------------------------------------------------
module grid_regional_minima_counter #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic [VALUE_BITS-1:0]                          in_cell_value,
  input  logic                                           in_last_cell,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic [$clog2(MAX_ROWS*MAX_COLS+1)-1:0]         out_minima_count,
  input  logic                                           cfg_we,
  input  logic [grmc_pkg::CFG_IDX_W-1:0]                 cfg_index,
  input  logic [grmc_pkg::CFG_W-1:0]                     cfg_wdata
);
  import grmc_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int TOT_W = $clog2(CELLS + 1);

  logic [CFG_W-1:0]  rows_cfg_r, cols_cfg_r;
  logic [CFG_W-1:0]  rows_eff, cols_eff;
  logic [2*CFG_W-1:0] prod;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  lp_r, lp_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [TOT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic              xfer_in, load_we, out_free;
  logic [ADDR_W-1:0] h_raddr;
  logic [VALUE_BITS-1:0] h_rdata;
  fill_stat_t        stat;
  logic [TOT_W-1:0]  count;

  always_comb begin
    if (rows_cfg_r == '0) rows_eff = CFG_W'(1);
    else if (32'(rows_cfg_r) > MAX_ROWS) rows_eff = CFG_W'(MAX_ROWS);
    else rows_eff = rows_cfg_r;
    if (cols_cfg_r == '0) cols_eff = CFG_W'(1);
    else if (32'(cols_cfg_r) > MAX_COLS) cols_eff = CFG_W'(MAX_COLS);
    else cols_eff = cols_cfg_r;
  end

  assign prod  = (2*CFG_W)'(rows_eff) * (2*CFG_W)'(cols_eff);
  assign total = TOT_W'(prod);

  assign in_ready = stat.idle;
  assign xfer_in  = in_valid && in_ready;
  assign load_we  = xfer_in && (lp_r < total);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    lp_nxt = lp_r;
    if (xfer_in) begin
      if (in_last_cell) lp_nxt = '0;
      else if (load_we) lp_nxt = lp_r + 1'b1;
    end
    out_valid_nxt = out_valid_r;
    out_cnt_nxt   = out_cnt_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (stat.done) begin
      out_valid_nxt = 1'b1;
      out_cnt_nxt   = count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r  <= DIM_RESET;
      cols_cfg_r  <= DIM_RESET;
      lp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_GRID_ROWS) rows_cfg_r <= cfg_wdata;
      if (cfg_we && cfg_index == REG_GRID_COLS) cols_cfg_r <= cfg_wdata;
      lp_r        <= lp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_cnt_r <= out_cnt_nxt;
  end

  grmc_ram #(.WIDTH(VALUE_BITS), .DEPTH(CELLS)) u_heights (
    .clk   (clk),
    .we    (load_we),
    .waddr (lp_r[ADDR_W-1:0]),
    .wdata (in_cell_value),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  grmc_fill #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS),
    .ADDR_W     (ADDR_W),
    .TOT_W      (TOT_W)
  ) u_fill (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (xfer_in && in_last_cell),
    .rows     (rows_eff),
    .cols     (cols_eff),
    .total    (total),
    .out_free (out_free),
    .h_raddr  (h_raddr),
    .h_rdata  (h_rdata),
    .stat     (stat),
    .count    (count)
  );

  assign out_valid        = out_valid_r;
  assign out_minima_count = out_cnt_r;

endmodule
